FILE: hw/rtl/pbc_pkg.sv
// Shared types and constants for the parking barrier controller.
// No dependencies; every module of the block imports this package.
package pbc_pkg;

    localparam int TIMER_WIDTH_DEFAULT = 16;
    localparam int NUM_SW = 5;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W = 16;

    // switch bit positions
    localparam int SW_LOWER = 0;
    localparam int SW_UPPER = 1;
    localparam int SW_ENTRY = 2;
    localparam int SW_EXIT = 3;
    localparam int SW_RESTART = 4;

    // request bit positions
    localparam int REQ_IN = 0;
    localparam int REQ_OUT = 1;

    localparam logic [NUM_SW-1:0] SW_RESET = 5'b00001;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MOVE = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLINK = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_HOLD = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_PAUSE = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_CAPACITY = 3'd5;

    localparam logic [7:0] DEBOUNCE_RESET = 8'h05;
    localparam logic [15:0] MOVE_RESET = 16'd600;
    localparam logic [15:0] BLINK_RESET = 16'd150;
    localparam logic [15:0] HOLD_RESET = 16'd1000;
    localparam logic [15:0] PAUSE_RESET = 16'd200;
    localparam logic [7:0] CAPACITY_RESET = 8'h0F;

    typedef enum logic [3:0] {
        PH_IDLE       = 4'd0,
        PH_FULL       = 4'd1,
        PH_RAISE      = 4'd2,
        PH_RAISED     = 4'd3,
        PH_HOLD       = 4'd4,
        PH_HOLD_PAUSE = 4'd5,
        PH_LOWER      = 4'd6,
        PH_LOWERED    = 4'd7,
        PH_FAULT      = 4'd8,
        PH_RESTART    = 4'd9
    } phase_t;

    typedef struct packed {
        logic [7:0]  debounce_ticks;
        logic [15:0] move_ticks;
        logic [15:0] blink_ticks;
        logic [15:0] hold_ticks;
        logic [15:0] pause_ticks;
        logic [7:0]  capacity;
    } cfg_t;

    typedef struct packed {
        logic       drive_raise;
        logic       drive_lower;
        logic       lamp;
        logic [7:0] spots_taken;
        logic       lot_full;
        logic       fault;
        logic [3:0] phase;
    } result_t;

endpackage

FILE: hw/rtl/parking_barrier_controller.sv
// Parking barrier controller top level: config registers, tick channel,
// result register. Depends on pbc_pkg, pbc_debounce and pbc_sequencer.
//
// Usage: each word on the s_ channel is one 5 ms tick with five raw switch
// levels. Every accepted tick produces exactly one result word on the m_
// channel with motor drives, lamp, occupancy, full and fault flags and the
// phase code after that tick's update.
// The result is registered: the result of a tick accepted at one edge is
// valid after that edge. One tick per cycle is taken while m_ready is high;
// debounce and phase update are one pass of logic on the state registers.
// The result register frees the input side: s_ready stays high while the
// held result is being taken, and drops only while m_valid is high and
// m_ready is low, so a stalled receiver holds the tick channel.
// The cfg_ channel writes the six timing and capacity registers by index
// (0 debounce, 1 move, 2 blink, 3 hold, 4 pause, 5 capacity); other indexes
// are ignored. cfg_ready is always high.
// Reset (aresetn low, synchronous) loads the register defaults, an idle
// lowered barrier, zero occupancy, lamp on and an empty result register.
module parking_barrier_controller
    import pbc_pkg::*;
#(
    parameter int TIMER_WIDTH = TIMER_WIDTH_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_lower_limit_raw,
    input  logic                   s_upper_limit_raw,
    input  logic                   s_entry_loop_raw,
    input  logic                   s_exit_loop_raw,
    input  logic                   s_restart_raw,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_drive_raise,
    output logic                   m_drive_lower,
    output logic                   m_lamp,
    output logic [7:0]             m_spots_taken,
    output logic                   m_lot_full,
    output logic                   m_fault,
    output logic [3:0]             m_phase,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t              cfg_reg;
    result_t           res_reg, res_next;
    logic              m_valid_reg, m_valid_next;
    logic              accept;
    logic [NUM_SW-1:0] raw;
    logic [NUM_SW-1:0] stable_next;

    assign cfg_ready = 1'b1;
    assign s_ready = !m_valid_reg || m_ready;
    assign accept = s_valid && s_ready;

    always_comb begin
        raw = '0;
        raw[SW_LOWER] = s_lower_limit_raw;
        raw[SW_UPPER] = s_upper_limit_raw;
        raw[SW_ENTRY] = s_entry_loop_raw;
        raw[SW_EXIT] = s_exit_loop_raw;
        raw[SW_RESTART] = s_restart_raw;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_ticks <= DEBOUNCE_RESET;
            cfg_reg.move_ticks <= MOVE_RESET;
            cfg_reg.blink_ticks <= BLINK_RESET;
            cfg_reg.hold_ticks <= HOLD_RESET;
            cfg_reg.pause_ticks <= PAUSE_RESET;
            cfg_reg.capacity <= CAPACITY_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_DEBOUNCE: cfg_reg.debounce_ticks <= cfg_data[7:0];
                CFG_MOVE:     cfg_reg.move_ticks <= cfg_data;
                CFG_BLINK:    cfg_reg.blink_ticks <= cfg_data;
                CFG_HOLD:     cfg_reg.hold_ticks <= cfg_data;
                CFG_PAUSE:    cfg_reg.pause_ticks <= cfg_data;
                CFG_CAPACITY: cfg_reg.capacity <= cfg_data[7:0];
                default:      cfg_reg <= cfg_reg;
            endcase
        end
    end

    pbc_debounce u_debounce (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .en             (accept),
        .debounce_ticks (cfg_reg.debounce_ticks),
        .raw            (raw),
        .stable_next    (stable_next)
    );

    pbc_sequencer #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_sequencer (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (accept),
        .cfg      (cfg_reg),
        .stable   (stable_next),
        .res_next (res_next)
    );

    // hold the result until taken, load a new one on every accepted tick
    always_comb begin
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            res_reg <= res_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_drive_raise = res_reg.drive_raise;
    assign m_drive_lower = res_reg.drive_lower;
    assign m_lamp = res_reg.lamp;
    assign m_spots_taken = res_reg.spots_taken;
    assign m_lot_full = res_reg.lot_full;
    assign m_fault = res_reg.fault;
    assign m_phase = res_reg.phase;

endmodule

FILE: hw/rtl/pbc_debounce.sv
// Per-switch debounce counters for the five raw switch levels.
// Depends on pbc_pkg.
module pbc_debounce
    import pbc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic [7:0]        debounce_ticks,
    input  logic [NUM_SW-1:0] raw,
    output logic [NUM_SW-1:0] stable_next
);

    logic [NUM_SW-1:0] raw_prev_reg;
    logic [NUM_SW-1:0] stable_reg;
    logic [7:0]        count_reg  [NUM_SW];
    logic [7:0]        count_next [NUM_SW];
    logic [7:0]        need;

    // a zero setting acts as one
    assign need = (debounce_ticks == 8'd0) ? 8'd1 : debounce_ticks;

    always_comb begin
        logic [8:0] c;
        stable_next = stable_reg;
        for (int i = 0; i < NUM_SW; i++) begin
            c = {1'b0, count_reg[i]} + 9'd1;
            if (raw[i] == raw_prev_reg[i]) begin
                if (c >= {1'b0, need}) begin
                    count_next[i] = 8'd0;
                    stable_next[i] = raw[i];
                end else begin
                    count_next[i] = c[7:0];
                end
            end else begin
                count_next[i] = 8'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            raw_prev_reg <= SW_RESET;
            stable_reg <= SW_RESET;
            for (int i = 0; i < NUM_SW; i++) begin
                count_reg[i] <= 8'd0;
            end
        end else if (en) begin
            raw_prev_reg <= raw;
            stable_reg <= stable_next;
            for (int i = 0; i < NUM_SW; i++) begin
                count_reg[i] <= count_next[i];
            end
        end
    end

endmodule

FILE: hw/rtl/pbc_sequencer.sv
// Barrier cycle sequencer: phase, timers, lamp, occupancy, requests, fault.
// Depends on pbc_pkg; takes debounced levels from pbc_debounce.
module pbc_sequencer
    import pbc_pkg::*;
#(
    parameter int TIMER_WIDTH = TIMER_WIDTH_DEFAULT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  cfg_t              cfg,
    input  logic [NUM_SW-1:0] stable,
    output result_t           res_next
);

    localparam int CW = ((TIMER_WIDTH > 16) ? TIMER_WIDTH : 16) + 1;

    phase_t                 phase_reg, phase_next;
    logic [TIMER_WIDTH-1:0] ptimer_reg, ptimer_next;
    logic [TIMER_WIDTH-1:0] btimer_reg, btimer_next;
    logic [7:0]             occ_reg, occ_next;
    logic                   lamp_reg, lamp_next;
    logic [1:0]             pend_reg, pend_next;
    logic [1:0]             cyc_reg, cyc_next;
    logic                   cross_reg, cross_next;
    logic                   fault_reg, fault_next;
    logic [NUM_SW-1:0]      sprev_reg, sprev_next;

    logic [NUM_SW-1:0]      rise;
    logic                   full;
    logic                   pt_done;
    logic                   bt_done;
    logic [TIMER_WIDTH-1:0] pt_inc;
    logic [TIMER_WIDTH-1:0] bt_inc;

    // count reaches limit, or counter sits at its maximum
    function automatic logic tick_done(input logic [TIMER_WIDTH-1:0] cnt,
                                       input logic [15:0] lim);
        logic [CW-1:0] t;
        t = CW'(cnt) + CW'(1);
        return (t >= CW'(lim)) || (&cnt);
    endfunction

    function automatic logic hold_reached(input logic [TIMER_WIDTH-1:0] cnt,
                                          input logic [15:0] lim);
        return (CW'(cnt) >= CW'(lim)) || (&cnt);
    endfunction

    assign rise = stable & ~sprev_reg;
    assign full = occ_reg >= cfg.capacity;
    assign pt_inc = ptimer_reg + TIMER_WIDTH'(1);
    assign bt_inc = btimer_reg + TIMER_WIDTH'(1);
    assign bt_done = tick_done(btimer_reg, cfg.blink_ticks);

    always_comb begin
        case (phase_reg)
            PH_RAISE, PH_LOWER: pt_done = tick_done(ptimer_reg, cfg.move_ticks);
            default:            pt_done = tick_done(ptimer_reg, cfg.pause_ticks);
        endcase
    end

    // next state
    always_comb begin
        logic [1:0]             req;
        logic [TIMER_WIDTH-1:0] held_t;
        logic [7:0]             occ1;
        phase_next = phase_reg;
        ptimer_next = ptimer_reg;
        btimer_next = btimer_reg;
        occ_next = occ_reg;
        lamp_next = lamp_reg;
        pend_next = pend_reg;
        cyc_next = cyc_reg;
        cross_next = cross_reg;
        fault_next = fault_reg;
        req = pend_reg;
        held_t = ptimer_reg;
        occ1 = occ_reg;
        case (phase_reg)
            PH_FULL: begin
                ptimer_next = pt_done ? '0 : pt_inc;
                if (pt_done) begin
                    phase_next = PH_IDLE;
                end
            end
            PH_RAISE, PH_LOWER: begin
                if (bt_done) begin
                    btimer_next = '0;
                    lamp_next = ~lamp_reg;
                end else begin
                    btimer_next = bt_inc;
                end
                ptimer_next = pt_done ? '0 : pt_inc;
                if (pt_done) begin
                    lamp_next = 1'b1;
                    btimer_next = '0;
                    phase_next = (phase_reg == PH_RAISE) ? PH_RAISED : PH_LOWERED;
                end
            end
            PH_RAISED: begin
                ptimer_next = pt_done ? '0 : pt_inc;
                if (pt_done) begin
                    if (stable[SW_UPPER]) begin
                        phase_next = PH_HOLD;
                    end else begin
                        phase_next = PH_FAULT;
                        fault_next = 1'b1;
                    end
                end
            end
            PH_HOLD: begin
                if ((cyc_reg[REQ_IN] && stable[SW_EXIT]) ||
                    (cyc_reg[REQ_OUT] && stable[SW_ENTRY])) begin
                    cross_next = 1'b1;
                end
                held_t = hold_reached(ptimer_reg, cfg.hold_ticks) ? ptimer_reg : pt_inc;
                ptimer_next = held_t;
                if (hold_reached(held_t, cfg.hold_ticks) &&
                    !(stable[SW_ENTRY] || stable[SW_EXIT])) begin
                    ptimer_next = '0;
                    phase_next = PH_HOLD_PAUSE;
                end
            end
            PH_HOLD_PAUSE: begin
                ptimer_next = pt_done ? '0 : pt_inc;
                if (pt_done) begin
                    if (!cross_reg) begin
                        occ1 = (cyc_reg[REQ_IN] && occ_reg != 8'hFF) ? occ_reg + 8'd1
                                                                    : occ_reg;
                        occ_next = (cyc_reg[REQ_OUT] && occ1 != 8'd0) ? occ1 - 8'd1
                                                                     : occ1;
                    end
                    phase_next = PH_LOWER;
                end
            end
            PH_LOWERED: begin
                ptimer_next = pt_done ? '0 : pt_inc;
                if (pt_done) begin
                    if (stable[SW_LOWER]) begin
                        phase_next = PH_IDLE;
                        pend_next = 2'b00;
                        cyc_next = 2'b00;
                        cross_next = 1'b0;
                    end else begin
                        phase_next = PH_FAULT;
                        fault_next = 1'b1;
                    end
                end
            end
            PH_FAULT: begin
                if (rise[SW_RESTART]) begin
                    phase_next = PH_RESTART;
                    ptimer_next = '0;
                end
            end
            PH_RESTART: begin
                ptimer_next = pt_done ? '0 : pt_inc;
                if (pt_done) begin
                    // re-arm requests for loops still occupied
                    if (stable[SW_ENTRY]) begin
                        pend_next[REQ_IN] = 1'b1;
                    end
                    if (stable[SW_EXIT]) begin
                        pend_next[REQ_OUT] = 1'b1;
                    end
                    fault_next = 1'b0;
                    phase_next = PH_IDLE;
                end
            end
            default: begin
                phase_next = PH_IDLE;
                if (rise[SW_ENTRY]) begin
                    req[REQ_IN] = 1'b1;
                end
                if (rise[SW_EXIT]) begin
                    req[REQ_OUT] = 1'b1;
                end
                if (req != 2'b00) begin
                    ptimer_next = '0;
                    if (req[REQ_IN] && full) begin
                        // refuse entry, keep any exit request waiting
                        pend_next = req & 2'b10;
                        phase_next = PH_FULL;
                    end else begin
                        pend_next = req;
                        cyc_next = req;
                        cross_next = 1'b0;
                        btimer_next = '0;
                        phase_next = PH_RAISE;
                    end
                end
            end
        endcase
    end

    // edges are tracked only while idle or in fault
    always_comb begin
        case (phase_reg)
            PH_FULL, PH_RAISE, PH_RAISED, PH_HOLD, PH_HOLD_PAUSE,
            PH_LOWER, PH_LOWERED, PH_RESTART: sprev_next = sprev_reg;
            default:                           sprev_next = stable;
        endcase
    end

    // result word
    always_comb begin
        res_next.drive_raise = (phase_next == PH_RAISE);
        res_next.drive_lower = (phase_next == PH_LOWER);
        res_next.lamp = lamp_next;
        res_next.spots_taken = occ_next;
        res_next.lot_full = (occ_next >= cfg.capacity);
        res_next.fault = fault_next;
        res_next.phase = phase_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            ptimer_reg <= '0;
            btimer_reg <= '0;
            occ_reg <= 8'd0;
            lamp_reg <= 1'b1;
            pend_reg <= 2'b00;
            cyc_reg <= 2'b00;
            cross_reg <= 1'b0;
            fault_reg <= 1'b0;
            sprev_reg <= SW_RESET;
        end else if (en) begin
            phase_reg <= phase_next;
            ptimer_reg <= ptimer_next;
            btimer_reg <= btimer_next;
            occ_reg <= occ_next;
            lamp_reg <= lamp_next;
            pend_reg <= pend_next;
            cyc_reg <= cyc_next;
            cross_reg <= cross_next;
            fault_reg <= fault_next;
            sprev_reg <= sprev_next;
        end
    end

endmodule
